// ===== rtl/cfa_pkg.sv =====
// cfa_pkg: shared constants, types and codes of the contiguous frame allocator.
// No dependencies.
`default_nettype none
package cfa_pkg;
    localparam int MAX_FRAMES_DEF = 1024;
    localparam int FRAME_W = 20;
    localparam int LEN_W   = 11;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_MARK    = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_RUN   = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_HEAD = 3'd3;
    localparam logic [STAT_W-1:0] ST_BUSY     = 3'd4;
    localparam logic [STAT_W-1:0] ST_BAD_LEN  = 3'd5;

    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN,
        S_CLAIM,
        S_REL_RD,
        S_REL,
        S_CHK_RD,
        S_CHK,
        S_DONE
    } cfa_state_t;

    // memory access request from sequencer to bitmap
    typedef struct packed {
        logic rd;
        logic wr;
        logic busy;
        logic head;
    } cfa_mem_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/cfa_bitmap.sv =====
// cfa_bitmap: busy/head bit memory, one synchronous read port, one write port.
// Depends on cfa_pkg.
`default_nettype none
module cfa_bitmap
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    localparam int AW = $clog2(MAX_FRAMES)
) (
    input  wire logic          clk,
    input  wire cfa_mem_ctl_t  ctl,
    input  wire logic [AW-1:0] rd_addr,
    input  wire logic [AW-1:0] wr_addr,
    output logic               rd_busy,
    output logic               rd_head
);
    logic [1:0] mem [MAX_FRAMES];

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            mem[wr_addr] <= {ctl.busy, ctl.head};
        end
        if (ctl.rd)
        begin
            {rd_busy, rd_head} <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/cfa_seq.sv =====
// cfa_seq: request sequencer; clear sweep, first-fit scan, claim, release, mark.
// Depends on cfa_pkg; drives cfa_bitmap.
`default_nettype none
module cfa_seq
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    localparam int AW = $clog2(MAX_FRAMES),
    localparam int CW = AW + 1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [FRAME_W-1:0] base,
    input  wire logic [LEN_W-1:0]   count_cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [FRAME_W-1:0] frame_number,
    input  wire logic [LEN_W-1:0]   run_length,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FRAME_W-1:0]      result_frame,
    output logic [STAT_W-1:0]       status,
    output logic [LEN_W-1:0]        frames_freed,
    output cfa_mem_ctl_t            mem_ctl,
    output logic [AW-1:0]           rd_addr,
    output logic [AW-1:0]           wr_addr,
    input  wire logic               rd_busy,
    input  wire logic               rd_head
);
    localparam int WW = (CW > LEN_W ? CW : LEN_W) + 1;

    cfa_state_t state_reg, state_next;
    logic [ACT_W-1:0]   act_reg;
    logic [FRAME_W-1:0] frm_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [WW-1:0]      cnt_reg;      // frames in the pool, count_cfg clamped to MAX_FRAMES
    logic [WW-1:0]      start_reg, start_next;
    logic [WW-1:0]      ptr_reg, ptr_next;
    logic [WW-1:0]      run_reg, run_next;
    logic [STAT_W-1:0]  st_reg, st_next;
    logic [FRAME_W-1:0] res_reg, res_next;
    logic [LEN_W-1:0]   fr_reg, fr_next;
    logic               ov_reg;
    logic               hd_reg, hd_next;

    logic [FRAME_W:0]   off;          // frame - base, sign in top bit
    logic [WW-1:0]      cnt_w, len_w, off_w, end_w;
    logic               below, off_big;

    assign cnt_w = (WW'(count_cfg) > WW'(MAX_FRAMES)) ? WW'(MAX_FRAMES) : WW'(count_cfg);
    assign off   = {1'b0, frm_reg} - {1'b0, base};
    assign below = off[FRAME_W];
    assign off_big = (FRAME_W > WW - 1) ? (|(off[FRAME_W-1:0] >> (WW - 1))) : 1'b0;
    assign off_w = WW'(off[FRAME_W-1:0]);
    assign len_w = WW'(len_reg);
    assign end_w = ptr_reg + WW'(1);

    assign in_ready = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign result_frame = res_reg;
    assign status = st_reg;
    assign frames_freed = fr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ov_reg    <= 1'b0;
            ptr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            if (state_reg == S_DONE)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg <= action;
            frm_reg <= frame_number;
            len_reg <= run_length;
            cnt_reg <= cnt_w;
        end
        start_reg <= start_next;
        run_reg   <= run_next;
        st_reg    <= st_next;
        res_reg   <= res_next;
        fr_reg    <= fr_next;
        hd_reg    <= hd_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (ptr_reg == WW'(MAX_FRAMES - 1)) state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready) state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (act_reg)
                    ACT_ALLOC:
                        if (len_w != '0 && len_w <= cnt_reg) state_next = S_SCAN_RD;
                    ACT_RELEASE:
                        if (!below && !off_big && off_w < cnt_reg) state_next = S_REL_RD;
                    ACT_MARK:
                        if (len_w != '0 && !below && !off_big
                            && off_w + len_w <= cnt_reg) state_next = S_CHK_RD;
                    default: state_next = S_DONE;
                endcase
            end
            S_SCAN_RD: state_next = S_SCAN;
            S_SCAN:
            begin
                if (!rd_busy && run_reg + WW'(1) == len_w) state_next = S_CLAIM;
                else if (!rd_busy && end_w < cnt_reg) state_next = S_SCAN;
                else if (rd_busy && end_w + len_w <= cnt_reg) state_next = S_SCAN;
                else state_next = S_DONE;
            end
            S_CHK_RD: state_next = S_CHK;
            S_CHK:
            begin
                if (rd_busy) state_next = S_DONE;
                else if (run_reg + WW'(1) == len_w) state_next = S_CLAIM;
            end
            S_CLAIM:
            begin
                if (ptr_reg + WW'(1) == start_reg + len_w) state_next = S_DONE;
            end
            S_REL_RD: state_next = S_REL;
            S_REL:
            begin
                if (hd_reg && (!rd_busy || !rd_head)) state_next = S_DONE;
                else if (!hd_reg && (!rd_busy || rd_head)) state_next = S_DONE;
                else if (end_w >= cnt_reg) state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        ptr_next   = ptr_reg;
        start_next = start_reg;
        run_next   = run_reg;
        st_next    = st_reg;
        res_next   = res_reg;
        fr_next    = fr_reg;
        hd_next    = hd_reg;
        mem_ctl    = '0;
        rd_addr    = AW'(ptr_reg);
        wr_addr    = AW'(ptr_reg);
        case (state_reg)
            S_CLEAR:
            begin
                mem_ctl.wr = 1'b1;
                ptr_next = ptr_reg + WW'(1);
            end
            S_DECODE:
            begin
                res_next = '0;
                fr_next  = '0;
                run_next = '0;
                hd_next  = 1'b1;
                st_next  = ST_BAD_LEN;
                case (act_reg)
                    ACT_ALLOC:
                    begin
                        ptr_next = '0;
                        start_next = '0;
                        st_next = (len_w != '0 && len_w <= cnt_reg) ? ST_NO_RUN : ST_BAD_LEN;
                    end
                    ACT_RELEASE:
                    begin
                        ptr_next = off_w;
                        st_next = ST_RANGE;
                    end
                    ACT_MARK:
                    begin
                        ptr_next = off_w;
                        start_next = off_w;
                        st_next = (len_w == '0) ? ST_BAD_LEN : ST_RANGE;
                    end
                    default: st_next = ST_BAD_LEN;
                endcase
            end
            S_SCAN_RD, S_CHK_RD, S_REL_RD:
            begin
                mem_ctl.rd = 1'b1;
            end
            S_SCAN:
            begin
                if (rd_busy)
                begin
                    start_next = end_w;
                    run_next = '0;
                    ptr_next = end_w;
                    mem_ctl.rd = 1'b1;
                    rd_addr = AW'(end_w);
                end
                else if (run_reg + WW'(1) == len_w)
                begin
                    ptr_next = start_reg;
                    st_next = ST_OK;
                    res_next = base + FRAME_W'(start_reg);
                end
                else
                begin
                    run_next = run_reg + WW'(1);
                    ptr_next = end_w;
                    mem_ctl.rd = 1'b1;
                    rd_addr = AW'(end_w);
                end
            end
            S_CHK:
            begin
                if (rd_busy)
                begin
                    st_next = ST_BUSY;
                end
                else if (run_reg + WW'(1) == len_w)
                begin
                    ptr_next = start_reg;
                    st_next = ST_OK;
                end
                else
                begin
                    run_next = run_reg + WW'(1);
                    ptr_next = end_w;
                    mem_ctl.rd = 1'b1;
                    rd_addr = AW'(end_w);
                end
            end
            S_CLAIM:
            begin
                mem_ctl.wr = 1'b1;
                mem_ctl.busy = 1'b1;
                mem_ctl.head = (ptr_reg == start_reg);
                ptr_next = end_w;
            end
            S_REL:
            begin
                hd_next = 1'b0;
                if (hd_reg && (!rd_busy || !rd_head))
                begin
                    st_next = ST_NOT_HEAD;
                end
                else if (hd_reg || (rd_busy && !rd_head))
                begin
                    st_next = ST_OK;
                    mem_ctl.wr = 1'b1;
                    fr_next = fr_reg + LEN_W'(1);
                    ptr_next = end_w;
                    if (end_w < cnt_reg)
                    begin
                        mem_ctl.rd = 1'b1;
                        rd_addr = AW'(end_w);
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_claim_ok: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.wr && mem_ctl.busy |-> st_reg == ST_OK) else $error("claim without ok");
    a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("accept while working");
    a_done_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && !out_ready |=> ov_reg && $stable(st_reg)) else $error("result lost");
`endif
endmodule
`default_nettype wire

// ===== rtl/contiguous_frame_allocator.sv =====
// Channel  | handshake            | payload
// input    | in_valid / in_ready  | action, frame_number, run_length
// output   | out_valid / out_ready| result_frame, status, frames_freed
// config   | cfg_we               | cfg_index, cfg_data
// One request is served at a time over one bitmap port. Allocate scans first-fit
// and claims run_length frames; release frees a run from its head frame onward;
// mark checks, then claims run_length frames. A bad length or action skips the bitmap.
// After reset, a clearing pass writes every bitmap entry before the first beat is taken.
// Output stalls hold the finished beat; the next beat is taken once it leaves.
// Top level; depends on cfa_pkg, cfa_bitmap, cfa_seq.
`default_nettype none
module contiguous_frame_allocator
    import cfa_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [FRAME_W-1:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [ACT_W-1:0]   action,
    input  wire logic [FRAME_W-1:0] frame_number,
    input  wire logic [LEN_W-1:0]   run_length,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [FRAME_W-1:0]      result_frame,
    output logic [STAT_W-1:0]       status,
    output logic [LEN_W-1:0]        frames_freed
);
    localparam int AW = $clog2(MAX_FRAMES);

    logic [FRAME_W-1:0] base_reg;
    logic [LEN_W-1:0]   count_reg;
    cfa_mem_ctl_t       mem_ctl;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               rd_busy, rd_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            count_reg <= LEN_W'(1024);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BASE) base_reg <= cfg_data;
            else count_reg <= cfg_data[LEN_W-1:0];
        end
    end

    cfa_bitmap #(.MAX_FRAMES(MAX_FRAMES)) u_bitmap (
        .clk(clk), .ctl(mem_ctl), .rd_addr(rd_addr), .wr_addr(wr_addr),
        .rd_busy(rd_busy), .rd_head(rd_head)
    );

    cfa_seq #(.MAX_FRAMES(MAX_FRAMES)) u_seq (
        .clk(clk), .rst_n(rst_n), .base(base_reg), .count_cfg(count_reg),
        .in_valid(in_valid), .in_ready(in_ready), .action(action),
        .frame_number(frame_number), .run_length(run_length),
        .out_valid(out_valid), .out_ready(out_ready), .result_frame(result_frame),
        .status(status), .frames_freed(frames_freed), .mem_ctl(mem_ctl),
        .rd_addr(rd_addr), .wr_addr(wr_addr), .rd_busy(rd_busy), .rd_head(rd_head)
    );
endmodule
`default_nettype wire

// ===== bench/contiguous_frame_allocator_test.sv =====
// Testbench for contiguous_frame_allocator: directed table, then random allocate/release/mark
// traffic over several pool settings, checked against a bitmap model. Depends on cfa_pkg.
`default_nettype none
module contiguous_frame_allocator_test;
    import cfa_pkg::*;

    localparam int NFR = 1024;
    localparam longint CYCLE_LIMIT = 8000000;

    typedef struct {
        logic [FRAME_W-1:0] rf;
        logic [STAT_W-1:0]  st;
        logic [LEN_W-1:0]   ff;
    } alloc_res_t;

    typedef struct {
        logic [ACT_W-1:0]   act;
        logic [FRAME_W-1:0] fr;
        logic [LEN_W-1:0]   len;
        bit                 known;
        logic [STAT_W-1:0]  st;
        logic [FRAME_W-1:0] rf;
        logic [LEN_W-1:0]   ff;
    } dir_row_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic cfg_index = 0;
    logic [FRAME_W-1:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_ready;
    logic [ACT_W-1:0] action = '0;
    logic [FRAME_W-1:0] frame_number = '0;
    logic [LEN_W-1:0] run_length = '0;
    logic out_valid;
    logic out_ready = 0;
    logic [FRAME_W-1:0] result_frame;
    logic [STAT_W-1:0] status;
    logic [LEN_W-1:0] frames_freed;

    bit row_known = 0;
    alloc_res_t row_typed;

    bit busy_bits[NFR];
    bit head_bits[NFR];
    longint pool_base = 0;
    longint pool_cnt = 1024;

    alloc_res_t due_q[$];
    alloc_res_t mon_r;
    alloc_res_t got_r;
    int fails = 0;
    longint cycles = 0;
    bit idle_on = 1;
    bit long_hold_req = 0;
    int hold_left = 0;
    dir_row_t dir_tab[21];

    contiguous_frame_allocator u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .frame_number(frame_number), .run_length(run_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_frame(result_frame), .status(status), .frames_freed(frames_freed)
    );

    always #6 clk = ~clk;

    function automatic longint frames_used();
        return (pool_cnt < NFR) ? pool_cnt : NFR;
    endfunction

    function automatic bit span_free(longint s, longint n);
        for (longint k = 0; k < n; k++)
            if (busy_bits[s + k])
                return 0;
        return 1;
    endfunction

    function automatic void take_span(longint s, longint n);
        for (longint k = 0; k < n; k++)
        begin
            busy_bits[s + k] = 1;
            head_bits[s + k] = 0;
        end
        head_bits[s] = 1;
    endfunction

    function automatic alloc_res_t predict_alloc(logic [ACT_W-1:0] a,
                                                 logic [FRAME_W-1:0] f,
                                                 logic [LEN_W-1:0] l);
        alloc_res_t r;
        longint n;
        longint fl;
        longint idx;
        n = frames_used();
        fl = f;
        r.rf = '0;
        r.st = ST_OK;
        r.ff = '0;
        if (a == ACT_ALLOC)
        begin
            if (l == 0 || l > n)
                r.st = ST_BAD_LEN;
            else
            begin
                r.st = ST_NO_RUN;
                for (longint i = 0; i + l <= n; i++)
                begin
                    if (span_free(i, l))
                    begin
                        take_span(i, l);
                        r.rf = FRAME_W'(pool_base + i);
                        r.st = ST_OK;
                        break;
                    end
                end
            end
        end
        else if (a == ACT_RELEASE)
        begin
            if (fl < pool_base || fl >= pool_base + n)
                r.st = ST_RANGE;
            else
            begin
                idx = fl - pool_base;
                if (!busy_bits[idx] || !head_bits[idx])
                    r.st = ST_NOT_HEAD;
                else
                begin
                    busy_bits[idx] = 0;
                    head_bits[idx] = 0;
                    r.ff = 1;
                    for (longint i = idx + 1; i < n && busy_bits[i] && !head_bits[i]; i++)
                    begin
                        busy_bits[i] = 0;
                        r.ff++;
                    end
                end
            end
        end
        else if (a == ACT_MARK)
        begin
            if (l == 0)
                r.st = ST_BAD_LEN;
            else if (fl < pool_base || fl + l > pool_base + n)
                r.st = ST_RANGE;
            else
            begin
                idx = fl - pool_base;
                if (!span_free(idx, l))
                    r.st = ST_BUSY;
                else
                    take_span(idx, l);
            end
        end
        else
            r.st = ST_BAD_LEN;
        return r;
    endfunction

    // scoreboard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[contiguous_frame_allocator] ERROR");
            $finish;
        end
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                mon_r = predict_alloc(action, frame_number, run_length);
                if (row_known)
                    mon_r = row_typed;
                due_q.push_back(mon_r);
            end
            if (out_valid && out_ready)
            begin
                if (due_q.size() == 0)
                begin
                    $display("%0t: unexpected beat frame=%0h status=%0d freed=%0d",
                             $time, result_frame, status, frames_freed);
                    fails++;
                end
                else
                begin
                    got_r = due_q.pop_front();
                    if (result_frame !== got_r.rf)
                    begin
                        $display("%0t: result_frame exp %0h got %0h", $time, got_r.rf, result_frame);
                        fails++;
                    end
                    if (status !== got_r.st)
                    begin
                        $display("%0t: status exp %0d got %0d", $time, got_r.st, status);
                        fails++;
                    end
                    if (frames_freed !== got_r.ff)
                    begin
                        $display("%0t: frames_freed exp %0d got %0d", $time, got_r.ff, frames_freed);
                        fails++;
                    end
                end
            end
        end
    end

    // output side: random stalls plus one long hold on request
    always @(posedge clk)
    begin
        if (long_hold_req && hold_left == 0)
        begin
            hold_left = 400;
            long_hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_ready <= 0;
            hold_left--;
        end
        else if (idle_on && $urandom_range(0, 9) == 0)
        begin
            out_ready <= 0;
            hold_left = $urandom_range(1, 10);
        end
        else
            out_ready <= 1;
    end

    task automatic cfg_write(logic idx, logic [FRAME_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 0;
        if (idx == CFG_BASE)
            pool_base = val;
        else
            pool_cnt = val & 20'h7FF;
    endtask

    task automatic drain();
        @(posedge clk);
        while (due_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send(logic [ACT_W-1:0] a, logic [FRAME_W-1:0] f, logic [LEN_W-1:0] l,
                        bit kn, alloc_res_t typed);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        in_valid <= 1;
        action <= a;
        frame_number <= f;
        run_length <= l;
        row_known <= kn;
        row_typed <= typed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic random_phase(int items, int long_at);
        alloc_res_t none;
        longint n;
        int r;
        int pick;
        logic [FRAME_W-1:0] f;
        logic [LEN_W-1:0] l;
        none = '{default: '0};
        for (int it = 0; it < items; it++)
        begin
            if (it == long_at)
                long_hold_req = 1;
            if (it == long_at + 40)
                long_hold_req = 0;
            n = frames_used();
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                l = ($urandom_range(0, 19) == 0) ? LEN_W'($urandom_range(1, 1024))
                                                 : LEN_W'($urandom_range(1, 8));
                send(ACT_ALLOC, FRAME_W'($urandom), l, 0, none);
            end
            else if (r < 75)
            begin
                f = FRAME_W'($urandom);
                if (n > 0)
                    for (int t = 0; t < 16; t++)
                    begin
                        pick = $urandom_range(0, n - 1);
                        if (head_bits[pick])
                        begin
                            f = FRAME_W'(pool_base + pick);
                            break;
                        end
                    end
                send(ACT_RELEASE, f, LEN_W'($urandom), 0, none);
            end
            else if (r < 85)
            begin
                f = FRAME_W'(pool_base + $urandom_range(0, n));
                send(ACT_MARK, f, LEN_W'($urandom_range(1, 6)), 0, none);
            end
            else
            begin
                f = ($urandom_range(0, 1)) ? FRAME_W'($urandom)
                                           : FRAME_W'(pool_base + $urandom_range(0, n));
                send(ACT_W'($urandom), f, LEN_W'($urandom), 0, none);
            end
        end
        in_valid <= 0;
    endtask

    initial
    begin
        alloc_res_t typed;
        dir_tab = '{
            '{ACT_ALLOC,   20'd0,    11'd0,    1, ST_BAD_LEN,  20'd0, 11'd0},
            '{ACT_ALLOC,   20'd0,    11'd1025, 1, ST_BAD_LEN,  20'd0, 11'd0},
            '{ACT_ALLOC,   20'd0,    11'd1,    1, ST_OK,       20'd0, 11'd0},
            '{ACT_ALLOC,   20'd0,    11'd3,    1, ST_OK,       20'd1, 11'd0},
            '{ACT_RELEASE, 20'd0,    11'd0,    1, ST_OK,       20'd0, 11'd1},
            '{ACT_RELEASE, 20'd2,    11'd0,    1, ST_NOT_HEAD, 20'd0, 11'd0},
            '{ACT_RELEASE, 20'd1,    11'd0,    1, ST_OK,       20'd0, 11'd3},
            '{ACT_RELEASE, 20'd1024, 11'd0,    1, ST_RANGE,    20'd0, 11'd0},
            '{ACT_MARK,    20'd10,   11'd5,    1, ST_OK,       20'd0, 11'd0},
            '{ACT_MARK,    20'd12,   11'd2,    1, ST_BUSY,     20'd0, 11'd0},
            '{ACT_MARK,    20'd1020, 11'd5,    1, ST_RANGE,    20'd0, 11'd0},
            '{ACT_MARK,    20'd1019, 11'd5,    1, ST_OK,       20'd0, 11'd0},
            '{ACT_MARK,    20'd50,   11'd0,    1, ST_BAD_LEN,  20'd0, 11'd0},
            '{2'd3,        20'hFFFFF, 11'h7FF, 1, ST_BAD_LEN,  20'd0, 11'd0},
            '{ACT_ALLOC,   20'd0,    11'd1024, 1, ST_NO_RUN,   20'd0, 11'd0},
            '{ACT_RELEASE, 20'd10,   11'd0,    1, ST_OK,       20'd0, 11'd5},
            '{ACT_RELEASE, 20'd1019, 11'd0,    1, ST_OK,       20'd0, 11'd5},
            '{ACT_ALLOC,   20'd0,    11'd1024, 1, ST_OK,       20'd0, 11'd0},
            '{ACT_RELEASE, 20'd0,    11'd0,    1, ST_OK,       20'd0, 11'd1024},
            '{ACT_MARK,    20'd0,    11'd1,    0, ST_OK,       20'd0, 11'd0},
            '{ACT_ALLOC,   20'd0,    11'd2,    0, ST_OK,       20'd0, 11'd0}
        };
        repeat (2) @(posedge clk);
        rst_n <= 1;
        foreach (dir_tab[i])
        begin
            typed = '{rf: dir_tab[i].rf, st: dir_tab[i].st, ff: dir_tab[i].ff};
            send(dir_tab[i].act, dir_tab[i].fr, dir_tab[i].len, dir_tab[i].known, typed);
        end
        in_valid <= 0;
        row_known <= 0;
        drain();

        random_phase(350, 150);
        drain();

        cfg_write(CFG_BASE, 20'hFFFF0);
        cfg_write(CFG_COUNT, 20'd64);
        random_phase(350, -1);
        drain();

        cfg_write(CFG_BASE, 20'h5A5A5);
        cfg_write(CFG_COUNT, 20'd1);
        random_phase(100, -1);
        drain();

        cfg_write(CFG_BASE, 20'd0);
        cfg_write(CFG_COUNT, 20'd0);
        random_phase(60, -1);
        drain();

        idle_on = 0;
        cfg_write(CFG_BASE, 20'd777);
        cfg_write(CFG_COUNT, 20'h7FF);
        random_phase(250, -1);
        drain();
        repeat (100) @(posedge clk);

        if (fails == 0 && due_q.size() == 0)
            $display("[contiguous_frame_allocator] OK");
        else
            $display("[contiguous_frame_allocator] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
